FILE: src/itoa_pkg.sv
// Shared types, constants and helpers for the integer to ASCII converter.
package itoa_pkg;

    localparam int VALUE_W    = 32;
    localparam int VALUE_BITS = 32;
    localparam int BASE_W     = 6;
    localparam int CHAR_W     = 8;
    localparam int DIGIT_W    = BASE_W;
    localparam int MAX_DIGITS = VALUE_BITS;
    localparam int STEP_W     = $clog2(VALUE_BITS);
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);

    localparam logic [BASE_W-1:0] BASE_MIN    = BASE_W'(2);
    localparam logic [BASE_W-1:0] BASE_MAX    = BASE_W'(36);
    localparam logic [BASE_W-1:0] SIGNED_BASE = BASE_W'(10);

    localparam logic [CHAR_W-1:0] CHAR_ZERO      = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_ALPHA_OFS = 8'h57;
    localparam logic [CHAR_W-1:0] CHAR_MINUS     = 8'h2D;
    localparam logic [DIGIT_W-1:0] DEC_LIMIT     = DIGIT_W'(10);

    typedef logic [VALUE_BITS-1:0] t_value;
    typedef logic [BASE_W-1:0]     t_base;
    typedef logic [DIGIT_W-1:0]    t_digit;
    typedef logic [CHAR_W-1:0]     t_char;
    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [STEP_W-1:0]     t_step;

    typedef struct packed {
        logic   done;
        logic   quot_zero;
        t_digit digit;
    } t_div_status;

    function automatic t_base sat_base(input t_base b, input logic is_signed);
        t_base r;
        if (is_signed) begin
            r = SIGNED_BASE;
        end else if (b < BASE_MIN) begin
            r = BASE_MIN;
        end else if (b > BASE_MAX) begin
            r = BASE_MAX;
        end else begin
            r = b;
        end
        return r;
    endfunction

    function automatic t_char digit_char(input t_digit d);
        t_char r;
        if (d < DEC_LIMIT) begin
            r = CHAR_ZERO + CHAR_W'(d);
        end else begin
            r = CHAR_ALPHA_OFS + CHAR_W'(d);
        end
        return r;
    endfunction

endpackage

FILE: src/itoa_ifs.sv
// Valid/ready channel interfaces for the request and the character stream.
interface itoa_in_if;
    logic                                valid;
    logic                                ready;
    logic [itoa_pkg::VALUE_W-1:0]        value;
    logic [itoa_pkg::BASE_W-1:0]         base;
    logic                                req_type;

    modport source (output valid, output value, output base, output req_type, input ready);
    modport sink   (input valid, input value, input base, input req_type, output ready);
endinterface

interface itoa_out_if;
    logic                                valid;
    logic                                ready;
    logic [itoa_pkg::CHAR_W-1:0]         char_code;
    logic                                last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

FILE: src/integer_to_ascii_digits.sv
// Top level: converts a 32-bit value to ASCII digits, most significant first.
// Each digit comes out of the bit-serial divider; the characters, with a leading minus
// sign for a negative signed value, follow once all digits are found. One item is in
// work at a time; the next is taken once the final character sits in the output
// register. Synchronous active-low reset clears the control state; the digit stack
// and datapath registers are not reset.
module integer_to_ascii_digits (
    input  logic        i_clk,
    input  logic        i_rst_n,
    itoa_in_if.sink     i_in,
    itoa_out_if.source  o_out
);
    import itoa_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_SIGN = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state      r_state, n_state;
    logic        r_neg;
    t_cnt        r_cnt;
    logic        r_out_valid;
    t_char       r_char;
    logic        r_last;
    t_base       r_base;

    logic        w_accept;
    logic        w_out_free;
    logic        w_push;
    logic        w_pop;
    logic        w_div_start;
    logic        w_in_neg;
    t_value      w_in_value;
    t_value      w_mag;
    t_value      w_dividend;
    t_base       w_base;
    t_base       w_divisor;
    t_value      w_quotient;
    t_div_status w_div_st;
    t_digit      w_top;
    logic        w_load_out;
    t_char       w_char;

    // Take a request only when the previous number has been fully handed over.
    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;

    // The output register is free when empty or being drained this cycle.
    assign w_out_free = !r_out_valid || o_out.ready;

    always_comb begin
        w_in_value = i_in.value[VALUE_BITS-1:0];
        w_in_neg   = i_in.req_type && w_in_value[VALUE_BITS-1];
        // Magnitude wraps modulo 2^VALUE_BITS, so the most negative value stays itself.
        w_mag      = w_in_neg ? VALUE_BITS'(~w_in_value + 1'b1) : w_in_value;
        w_base     = sat_base(i_in.base, i_in.req_type);
    end

    // Restart the divider on a new request, or keep dividing the running quotient
    // until it reaches zero. Digits come out least significant first.
    assign w_push      = (r_state == S_DIV) && w_div_st.done;
    assign w_div_start = w_accept || (w_push && !w_div_st.quot_zero);
    assign w_dividend  = w_accept ? w_mag : w_quotient;
    // Later digits reuse the radix captured with the transaction, not the live bus.
    assign w_divisor   = w_accept ? w_base : r_base;

    // Pop digits back out in reverse, so the most significant one goes first.
    assign w_pop      = (r_state == S_EMIT) && w_out_free;
    assign w_load_out = ((r_state == S_SIGN) || (r_state == S_EMIT)) && w_out_free;
    assign w_char     = (r_state == S_SIGN) ? CHAR_MINUS : digit_char(w_top);

    itoa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_quotient (w_quotient),
        .o_status   (w_div_st)
    );

    itoa_lifo u_lifo (
        .i_clk   (i_clk),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .i_digit (w_div_st.digit),
        .o_top   (w_top)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_push && w_div_st.quot_zero) begin
                    n_state = r_neg ? S_SIGN : S_EMIT;
                end
            end
            S_SIGN: begin
                if (w_out_free) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free && (r_cnt == t_cnt'(1))) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_neg       <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_neg <= w_in_neg;
                r_cnt <= '0;
            end else if (w_push) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
            // Hold a waiting character; advance once the sink takes it.
            if (w_out_free) begin
                r_out_valid <= w_load_out;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_base <= w_base;
        end
        if (w_load_out) begin
            r_char <= w_char;
            r_last <= (r_state == S_EMIT) && (r_cnt == t_cnt'(1));
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.char_code = r_char;
    assign o_out.last_char = r_last;

endmodule

FILE: src/itoa_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, small remainder.
module itoa_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  itoa_pkg::t_value      i_dividend,
    input  itoa_pkg::t_base       i_divisor,
    output itoa_pkg::t_value      o_quotient,
    output itoa_pkg::t_div_status o_status
);
    import itoa_pkg::*;

    logic                r_active;
    logic                r_done;
    t_step               r_step;
    t_value              r_q;
    t_digit              r_r;
    t_base               r_div;

    logic [DIGIT_W:0]    w_trial;
    logic [DIGIT_W:0]    w_diff;
    logic                w_ge;
    t_digit              n_r;

    always_comb begin
        w_trial = {r_r, r_q[VALUE_BITS-1]};
        w_diff  = w_trial - {1'b0, r_div};
        w_ge    = (w_trial >= {1'b0, r_div});
        n_r     = w_ge ? w_diff[DIGIT_W-1:0] : w_trial[DIGIT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_done   <= 1'b0;
            r_step   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_active <= 1'b1;
                r_step   <= STEP_W'(VALUE_BITS - 1);
            end else if (r_active) begin
                r_step <= r_step - 1'b1;
                if (r_step == '0) begin
                    r_active <= 1'b0;
                    r_done   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_r   <= '0;
            r_div <= i_divisor;
        end else if (r_active) begin
            r_q <= {r_q[VALUE_BITS-2:0], w_ge};
            r_r <= n_r;
        end
    end

    assign o_quotient         = r_q;
    assign o_status.done      = r_done;
    assign o_status.quot_zero = (r_q == '0);
    assign o_status.digit     = r_r;

endmodule

FILE: src/itoa_lifo.sv
// Shift-register digit stack: push at the top, pop from the top.
module itoa_lifo (
    input  logic             i_clk,
    input  logic             i_push,
    input  logic             i_pop,
    input  itoa_pkg::t_digit i_digit,
    output itoa_pkg::t_digit o_top
);
    import itoa_pkg::*;

    t_digit r_mem [MAX_DIGITS];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[0] <= i_digit;
            for (int i = 1; i < MAX_DIGITS; i++) begin
                r_mem[i] <= r_mem[i-1];
            end
        end else if (i_pop) begin
            for (int i = 0; i < MAX_DIGITS - 1; i++) begin
                r_mem[i] <= r_mem[i+1];
            end
        end
    end

    assign o_top = r_mem[0];

endmodule
